FILE: design/ostb_pkg.sv
// shared types and constants for the one-shot timer bank
`default_nettype none

package ostb_pkg;

  localparam int CmdW   = 3;
  localparam int SlotW  = 3;
  localparam int CountW = 17;
  localparam int FiredW = 5;
  // fired_mask, alloc_ok, alloc_slot packed and filled up to whole bytes
  localparam int OutFieldW = FiredW + 1 + SlotW;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  typedef enum logic [CmdW-1:0] {
    CmdTick    = 3'd0,
    CmdAlloc   = 3'd1,
    CmdRelease = 3'd2,
    CmdStart   = 3'd3,
    CmdStop    = 3'd4
  } cmd_e;

  // item as it walks down the row of slot cells
  typedef struct packed {
    logic              valid;
    cmd_e              cmd;
    logic [SlotW-1:0]  slot_id;
    logic [CountW-1:0] load;
    logic              handler;
    logic              alloc_done;
    logic [SlotW-1:0]  alloc_slot;
    logic [FiredW-1:0] fired;
  } tok_t;

endpackage

`default_nettype wire

FILE: design/ostb_cell.sv
// one timer slot: holds its state and passes the item on to the next slot
`default_nettype none

module ostb_cell
  import ostb_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  tok_t tok_i,
  input  wire  take_i,
  output tok_t tok_o,
  output logic busy_o
);

  tok_t              tok_q, tok_d;
  logic              valid_q, valid_d;
  logic              armed_q, armed_d;
  logic              handler_q, handler_d;
  logic [CountW-1:0] count_q, count_d;
  logic              mine;
  logic              fire;

  assign mine   = (32'(tok_q.slot_id) == IDX) && valid_q;
  assign fire   = tok_q.valid && take_i;
  assign busy_o = tok_q.valid;

  always_comb begin
    tok_o     = tok_q;
    valid_d   = valid_q;
    armed_d   = armed_q;
    handler_d = handler_q;
    count_d   = count_q;
    case (tok_q.cmd)
      CmdTick: begin
        if (valid_q) begin
          if (count_q != '0) begin
            count_d = count_q - CountW'(1);
          end else if (armed_q && handler_q) begin
            armed_d     = 1'b0;
            tok_o.fired = tok_q.fired | (FiredW'(1) << IDX);
          end
        end
      end
      CmdAlloc: begin
        // lowest free slot wins, later slots see alloc_done
        if (!tok_q.alloc_done && !valid_q) begin
          valid_d          = 1'b1;
          armed_d          = 1'b0;
          count_d          = '0;
          handler_d        = tok_q.handler;
          tok_o.alloc_done = 1'b1;
          tok_o.alloc_slot = SlotW'(IDX);
        end
      end
      CmdRelease: begin
        if (mine) begin
          valid_d   = 1'b0;
          armed_d   = 1'b0;
          handler_d = 1'b0;
          count_d   = '0;
        end
      end
      CmdStart: begin
        if (mine) begin
          count_d = tok_q.load;
          armed_d = 1'b1;
        end
      end
      CmdStop: begin
        if (mine) begin
          armed_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    tok_d = tok_q;
    if (tok_i.valid) begin
      tok_d = tok_i;
    end else if (fire) begin
      tok_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= '0;
      valid_q   <= 1'b0;
      armed_q   <= 1'b0;
      handler_q <= 1'b0;
      count_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (fire) begin
        valid_q   <= valid_d;
        armed_q   <= armed_d;
        handler_q <= handler_d;
        count_q   <= count_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/one_shot_timer_bank.sv
// top level of the one-shot timer bank
`default_nettype none

// Pool of NUM_TIMERS one-shot countdown timers, one per cell in a row. Each
// command item (tick, allocate, release, start, stop) enters the first cell
// and moves one cell per clock until it reaches the last cell; every cell
// updates its own slot as the item passes, and the last cell hands the result
// to the output register. One item is in the row at a time; the next is
// taken as soon as the row is empty, even while the previous result still
// waits on the output, so a new item is never taken before the last one has
// left the row. While the output register holds a result that is not yet
// taken, an item that reaches the last cell waits there. Every item yields
// one result.
module one_shot_timer_bank
  import ostb_pkg::*;
#(
  parameter int NUM_TIMERS    = 5,
  parameter int SECONDS_WIDTH = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  // slot_id[2:0], seconds, handler_present, zero fill
  input  wire  [((SECONDS_WIDTH+SlotW+1+7)/8)*8-1:0] s_axis_tdata,
  // command
  input  wire  [CmdW-1:0]     s_axis_tuser,
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  // fired_mask[4:0], alloc_ok[5], alloc_slot[8:6], zero fill
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int HandlerPos = SlotW + SECONDS_WIDTH;

  tok_t                    tok_in;
  tok_t                    chain [NUM_TIMERS+1];
  logic [NUM_TIMERS-1:0]   busy;
  logic                    out_free;
  logic                    m_valid_q, m_valid_d;
  logic [OutDataW-1:0]     m_data_q, m_data_d;
  logic [SECONDS_WIDTH-1:0] seconds;
  tok_t                    last;

  assign seconds       = s_axis_tdata[SlotW +: SECONDS_WIDTH];
  assign s_axis_tready = ~|busy;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    tok_in            = '0;
    tok_in.valid      = s_axis_tvalid && s_axis_tready;
    tok_in.cmd        = cmd_e'(s_axis_tuser);
    tok_in.slot_id    = s_axis_tdata[SlotW-1:0];
    tok_in.load       = CountW'({seconds, 1'b0});
    tok_in.handler    = s_axis_tdata[HandlerPos];
  end

  assign chain[0] = tok_in;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    ostb_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (chain[i]),
      .take_i((i == NUM_TIMERS - 1) ? out_free : 1'b1),
      .tok_o (chain[i+1]),
      .busy_o(busy[i])
    );
  end

  assign last = chain[NUM_TIMERS];

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (last.valid && out_free) begin
      m_valid_d = 1'b1;
      m_data_d  = OutDataW'({last.alloc_slot, last.alloc_done, last.fired});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire
